>>> rtl/barometer_pressure_temp_compensation_defines.svh
// assertion macros used by the checker file of the barometer compensation block
`ifndef BAROMETER_PRESSURE_TEMP_COMPENSATION_DEFINES_SVH
`define BAROMETER_PRESSURE_TEMP_COMPENSATION_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define BPTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define BPTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bptc_pkg.sv
// types and constants shared by the barometer compensation modules
`timescale 1ns / 1ps

package bptc_pkg;

  localparam int unsigned CoeffW    = 16;
  localparam int unsigned RawW      = 24;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned TempW     = 19;
  localparam int unsigned OffW      = 36;
  localparam int unsigned SensW     = 35;
  localparam int unsigned T2HiW     = 13;
  localparam int unsigned T2LoW     = 17;
  localparam int unsigned OutTempW  = 16;
  localparam int unsigned OutPressW = 32;

  // first-order temperature thresholds in centidegrees
  localparam logic signed [TempW-1:0] TempRef  = TempW'(2000);
  localparam logic signed [TempW-1:0] TempVlow = TempW'(-1500);
  localparam logic signed [TempW-1:0] TempMin  = TempW'(-5000);
  localparam logic signed [TempW-1:0] TempMax  = TempW'(10000);

  typedef enum logic [CfgIdxW-1:0] {
    REG_SENS_COEFF      = 3'd0,
    REG_OFFSET_COEFF    = 3'd1,
    REG_SENS_TEMPCO     = 3'd2,
    REG_OFFSET_TEMPCO   = 3'd3,
    REG_REF_TEMPERATURE = 3'd4,
    REG_TEMP_COEFF      = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CLS_RANGE,
    CLS_HIGH,
    CLS_LOW,
    CLS_VLOW
  } temp_cls_e;

  typedef struct packed {
    logic [CoeffW-1:0] sens_coeff;
    logic [CoeffW-1:0] offset_coeff;
    logic [CoeffW-1:0] sens_tempco;
    logic [CoeffW-1:0] offset_tempco;
    logic [CoeffW-1:0] ref_temperature;
    logic [CoeffW-1:0] temp_coeff;
  } cal_t;

  // first-order result of one sample, handed from front to back
  typedef struct packed {
    logic        [RawW-1:0]  d1;
    logic signed [TempW-1:0] temp;
    logic signed [OffW-1:0]  off;
    logic signed [SensW-1:0] sens;
    logic        [T2HiW-1:0] t2_hi;
    logic        [T2LoW-1:0] t2_lo;
    temp_cls_e               cls;
  } item_t;

endpackage

>>> rtl/bptc_front.sv
// front end: input transfer, first-order terms and temperature class
`timescale 1ns / 1ps

module bptc_front #(
  parameter int unsigned QueueDepth = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [bptc_pkg::RawW-1:0]    raw_press_i,
  input  logic [bptc_pkg::RawW-1:0]    raw_temp_i,
  input  bptc_pkg::cal_t               cal_i,
  input  logic                         pop_i,
  output logic                         push_o,
  output bptc_pkg::item_t              item_o
);

  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned DtW  = bptc_pkg::RawW + 1;
  localparam int unsigned MulW = DtW + bptc_pkg::CoeffW;
  localparam int unsigned SqW  = 2 * bptc_pkg::RawW + 1;

  logic            accept;
  logic [CntW-1:0] count_q, count_d;

  logic                      v1_q, v2_q, v3_q;
  logic [bptc_pkg::RawW-1:0] d1_1_q, d1_2_q;
  logic signed [DtW-1:0]     dt_d, dt_1_q;
  logic signed [MulW-1:0]    tmul_d, offmul_d, sensmul_d;
  logic signed [MulW-1:0]    tmul_2_q, offmul_2_q, sensmul_2_q;
  logic signed [2*DtW-1:0]   sq_full;
  logic [SqW-1:0]            dtsq_2_q;
  logic [SqW+1:0]            m5;
  logic [SqW:0]              m3;
  bptc_pkg::item_t           item_d, item_q;

  // items in the front plus entries in the queue never exceed its depth
  assign in_ready_o = count_q < CntW'(QueueDepth);
  assign accept     = in_valid_i && in_ready_o;
  assign count_d    = count_q + CntW'(accept) - CntW'(pop_i);

  // dT = D2 - C5 * 2^8
  assign dt_d = $signed({1'b0, raw_temp_i}) - $signed({1'b0, cal_i.ref_temperature, 8'h00});

  assign tmul_d    = dt_1_q * $signed({1'b0, cal_i.temp_coeff});
  assign offmul_d  = dt_1_q * $signed({1'b0, cal_i.offset_tempco});
  assign sensmul_d = dt_1_q * $signed({1'b0, cal_i.sens_tempco});
  assign sq_full   = dt_1_q * dt_1_q;

  assign m5 = {2'b00, dtsq_2_q} + {dtsq_2_q, 2'b00};
  assign m3 = {1'b0, dtsq_2_q} + {dtsq_2_q, 1'b0};

  always_comb begin
    item_d.d1    = d1_2_q;
    item_d.temp  = bptc_pkg::TempRef + bptc_pkg::TempW'($signed(tmul_2_q[MulW-1:23]));
    item_d.off   = $signed({3'b000, cal_i.offset_coeff, 17'h00000})
                 + bptc_pkg::OffW'($signed(offmul_2_q[MulW-1:6]));
    item_d.sens  = $signed({3'b000, cal_i.sens_coeff, 16'h0000})
                 + bptc_pkg::SensW'($signed(sensmul_2_q[MulW-1:7]));
    item_d.t2_hi = m5[SqW+1:38];
    item_d.t2_lo = m3[SqW:33];
    if (item_d.temp < bptc_pkg::TempMin || item_d.temp > bptc_pkg::TempMax) begin
      item_d.cls = bptc_pkg::CLS_RANGE;
    end else if (item_d.temp >= bptc_pkg::TempRef) begin
      item_d.cls = bptc_pkg::CLS_HIGH;
    end else if (item_d.temp < bptc_pkg::TempVlow) begin
      item_d.cls = bptc_pkg::CLS_VLOW;
    end else begin
      item_d.cls = bptc_pkg::CLS_LOW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      v1_q    <= accept;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d1_1_q      <= raw_press_i;
    dt_1_q      <= dt_d;
    d1_2_q      <= d1_1_q;
    tmul_2_q    <= tmul_d;
    offmul_2_q  <= offmul_d;
    sensmul_2_q <= sensmul_d;
    dtsq_2_q    <= sq_full[SqW-1:0];
    item_q      <= item_d;
  end

  assign push_o = v3_q;
  assign item_o = item_q;

endmodule

>>> rtl/bptc_queue.sv
// small first-in first-out queue between front and back
`timescale 1ns / 1ps

module bptc_queue #(
  parameter int unsigned Depth = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bptc_pkg::item_t item_i,
  input  logic            pop_i,
  output logic            valid_o,
  output bptc_pkg::item_t item_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  bptc_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign valid_o = count_q != '0;
  assign item_o  = mem_q[rd_ptr_q];

  // the front holds back input so a push never meets a full queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> rtl/bptc_back.sv
// back end: second-order corrections, pressure product and output register
`timescale 1ns / 1ps

module bptc_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                head_valid_i,
  input  bptc_pkg::item_t                     head_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [bptc_pkg::OutTempW-1:0]  temp_centideg_o,
  output logic signed [bptc_pkg::OutPressW-1:0] press_centimbar_o,
  output logic                                valid_res_o
);

  localparam int unsigned TW    = bptc_pkg::TempW;
  localparam int unsigned OW    = bptc_pkg::OffW;
  localparam int unsigned SW    = bptc_pkg::SensW;
  localparam int unsigned RW    = bptc_pkg::RawW;
  localparam int unsigned OTW   = bptc_pkg::OutTempW;
  localparam int unsigned TcW   = TW + 1;
  localparam int unsigned DW    = 14;
  localparam int unsigned EW    = 13;
  localparam int unsigned DsqW  = 26;
  localparam int unsigned EsqW  = 24;
  localparam int unsigned Off2W = 29;
  localparam int unsigned Sen2W = 28;
  localparam int unsigned LoW   = 18;
  localparam int unsigned HiW   = SW - LoW;
  localparam int unsigned PloW  = RW + LoW;
  localparam int unsigned PhiW  = RW + 1 + HiW;
  localparam int unsigned ProdW = PhiW + LoW;
  localparam int unsigned ShW   = ProdW - 21;
  localparam int unsigned DfW   = ShW + 1;

  localparam logic signed [TcW-1:0] TcHi = TcW'(20000);
  localparam logic signed [TcW-1:0] TcLo = TcW'(-20000);
  localparam logic signed [TW-1:0]  VlowOfs = TW'(1500);

  logic adv;

  // stage 1
  logic signed [TW-1:0]    d_full, e_full;
  logic signed [2*DW-1:0]  dsq_full;
  logic signed [2*EW-1:0]  esq_full;
  logic [bptc_pkg::T2LoW-1:0] t2;
  logic signed [TcW-1:0]   tcw;
  logic signed [OTW-1:0]   tc_d;
  logic                    v1_q;
  logic [RW-1:0]           d1_1_q;
  logic signed [OW-1:0]    off_1_q;
  logic signed [SW-1:0]    sens_1_q;
  bptc_pkg::temp_cls_e     cls_1_q;
  logic signed [OTW-1:0]   tc_1_q;
  logic [DsqW-1:0]         dsq_1_q;
  logic [EsqW-1:0]         esq_1_q;

  // stage 2
  logic [31:0]             m61;
  logic [30:0]             m29;
  logic [Off2W-1:0]        m17;
  logic [Sen2W-1:0]        m9;
  logic [Off2W-1:0]        off2_d;
  logic [Sen2W-1:0]        sens2_d;
  logic                    v2_q;
  logic [RW-1:0]           d1_2_q;
  logic signed [OW-1:0]    off_2_q;
  logic signed [SW-1:0]    sens_2_q;
  bptc_pkg::temp_cls_e     cls_2_q;
  logic signed [OTW-1:0]   tc_2_q;
  logic [Off2W-1:0]        off2_2_q;
  logic [Sen2W-1:0]        sens2_2_q;

  // stage 3
  logic                    v3_q;
  logic [RW-1:0]           d1_3_q;
  logic signed [OW-1:0]    offc_3_q;
  logic signed [SW-1:0]    sensc_3_q;
  bptc_pkg::temp_cls_e     cls_3_q;
  logic signed [OTW-1:0]   tc_3_q;

  // stage 4
  logic [PloW-1:0]         plo_d;
  logic signed [PhiW-1:0]  phi_d;
  logic                    v4_q;
  logic [PloW-1:0]         plo_4_q;
  logic signed [PhiW-1:0]  phi_4_q;
  logic signed [OW-1:0]    offc_4_q;
  bptc_pkg::temp_cls_e     cls_4_q;
  logic signed [OTW-1:0]   tc_4_q;

  // stage 5
  logic                    v5_q;
  logic signed [ProdW-1:0] prod_5_q;
  logic signed [OW-1:0]    offc_5_q;
  bptc_pkg::temp_cls_e     cls_5_q;
  logic signed [OTW-1:0]   tc_5_q;

  // output register
  logic signed [DfW-1:0]   diff;
  logic                    out_valid_q;
  logic signed [OTW-1:0]   temp_q;
  logic signed [bptc_pkg::OutPressW-1:0] press_q;
  logic                    vres_q;

  // the whole back pipeline moves when the output register can take a value
  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv && head_valid_i;

  // stage 1: squared distances and corrected temperature
  always_comb begin
    d_full   = head_i.temp - bptc_pkg::TempRef;
    e_full   = head_i.temp + VlowOfs;
    dsq_full = $signed(d_full[DW-1:0]) * $signed(d_full[DW-1:0]);
    esq_full = $signed(e_full[EW-1:0]) * $signed(e_full[EW-1:0]);
    t2       = (head_i.cls == bptc_pkg::CLS_HIGH) ? {4'h0, head_i.t2_hi} : head_i.t2_lo;
    tcw      = TcW'(head_i.temp) - $signed({3'b000, t2});
    if (tcw < TcLo) begin
      tc_d = OTW'(TcLo);
    end else if (tcw > TcHi) begin
      tc_d = OTW'(TcHi);
    end else begin
      tc_d = tcw[OTW-1:0];
    end
  end

  // stage 2: OFF2 and SENS2 by class
  always_comb begin
    m61 = {6'b000000, dsq_1_q} * 32'd61;
    m29 = {5'b00000, dsq_1_q} * 31'd29;
    m17 = {5'b00000, esq_1_q} * 29'd17;
    m9  = {4'h0, esq_1_q} * 28'd9;
    case (cls_1_q)
      bptc_pkg::CLS_LOW: begin
        off2_d  = Off2W'(m61[31:4]);
        sens2_d = Sen2W'(m29[30:4]);
      end
      bptc_pkg::CLS_VLOW: begin
        off2_d  = Off2W'(m61[31:4]) + m17;
        sens2_d = Sen2W'(m29[30:4]) + m9;
      end
      default: begin
        off2_d  = '0;
        sens2_d = '0;
      end
    endcase
  end

  // stage 4: D1 * SENS split into two partial products
  assign plo_d = PloW'(d1_3_q) * PloW'(sensc_3_q[LoW-1:0]);
  assign phi_d = $signed({1'b0, d1_3_q}) * $signed(sensc_3_q[SW-1:LoW]);

  // output: ((D1 * SENS) >> 21 - OFF) >> 15, always within 25 bits
  assign diff = DfW'($signed(prod_5_q[ProdW-1:21])) - DfW'(offc_5_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= head_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      out_valid_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d1_1_q    <= head_i.d1;
      off_1_q   <= head_i.off;
      sens_1_q  <= head_i.sens;
      cls_1_q   <= head_i.cls;
      tc_1_q    <= tc_d;
      dsq_1_q   <= dsq_full[DsqW-1:0];
      esq_1_q   <= esq_full[EsqW-1:0];

      d1_2_q    <= d1_1_q;
      off_2_q   <= off_1_q;
      sens_2_q  <= sens_1_q;
      cls_2_q   <= cls_1_q;
      tc_2_q    <= tc_1_q;
      off2_2_q  <= off2_d;
      sens2_2_q <= sens2_d;

      d1_3_q    <= d1_2_q;
      offc_3_q  <= off_2_q - $signed({7'h00, off2_2_q});
      sensc_3_q <= sens_2_q - $signed({7'h00, sens2_2_q});
      cls_3_q   <= cls_2_q;
      tc_3_q    <= tc_2_q;

      plo_4_q   <= plo_d;
      phi_4_q   <= phi_d;
      offc_4_q  <= offc_3_q;
      cls_4_q   <= cls_3_q;
      tc_4_q    <= tc_3_q;

      prod_5_q  <= $signed({phi_4_q, {LoW{1'b0}}}) + $signed({{LoW{1'b0}}, plo_4_q});
      offc_5_q  <= offc_4_q;
      cls_5_q   <= cls_4_q;
      tc_5_q    <= tc_4_q;

      if (cls_5_q == bptc_pkg::CLS_RANGE) begin
        temp_q  <= '0;
        press_q <= '0;
        vres_q  <= 1'b0;
      end else begin
        temp_q  <= tc_5_q;
        press_q <= bptc_pkg::OutPressW'($signed(diff[DfW-1:15]));
        vres_q  <= 1'b1;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign temp_centideg_o   = temp_q;
  assign press_centimbar_o = press_q;
  assign valid_res_o       = vres_q;

endmodule

>>> rtl/barometer_pressure_temp_compensation.sv
// Barometer compensation: one raw pressure/temperature pair in, one compensated
// temperature (0.01 C) and pressure (0.01 mbar) out. One pair can be taken every
// cycle while input ready is high; a result passes 3 front stages, one queue
// slot, 5 back stages and the output register. Input ready follows an item count
// over the front stages and the QueueDepth-entry queue, so the back end can stall
// on the output while the front keeps taking samples until that count hits QueueDepth.
// Calibration words C1..C6 are written at indexes 0..5, other indexes are dropped; the user
// must write them only while the block is idle, which the block does not enforce.
`timescale 1ns / 1ps

module barometer_pressure_temp_compensation #(
  parameter int unsigned QueueDepth = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [bptc_pkg::RawW-1:0]             raw_press_i,
  input  logic [bptc_pkg::RawW-1:0]             raw_temp_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [bptc_pkg::OutTempW-1:0]  temp_centideg_o,
  output logic signed [bptc_pkg::OutPressW-1:0] press_centimbar_o,
  output logic                                  valid_res_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [bptc_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [bptc_pkg::CoeffW-1:0]           cfg_data_i
);

  bptc_pkg::cal_t  cal_q;
  logic            push, pop, head_valid;
  bptc_pkg::item_t push_item, head_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (cfg_valid_i) begin
      case (bptc_pkg::cfg_reg_e'(cfg_index_i))
        bptc_pkg::REG_SENS_COEFF:      cal_q.sens_coeff      <= cfg_data_i;
        bptc_pkg::REG_OFFSET_COEFF:    cal_q.offset_coeff    <= cfg_data_i;
        bptc_pkg::REG_SENS_TEMPCO:     cal_q.sens_tempco     <= cfg_data_i;
        bptc_pkg::REG_OFFSET_TEMPCO:   cal_q.offset_tempco   <= cfg_data_i;
        bptc_pkg::REG_REF_TEMPERATURE: cal_q.ref_temperature <= cfg_data_i;
        bptc_pkg::REG_TEMP_COEFF:      cal_q.temp_coeff      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  bptc_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .raw_press_i (raw_press_i),
    .raw_temp_i  (raw_temp_i),
    .cal_i       (cal_q),
    .pop_i       (pop),
    .push_o      (push),
    .item_o      (push_item)
  );

  bptc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .valid_o (head_valid),
    .item_o  (head_item)
  );

  bptc_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_valid_i      (head_valid),
    .head_i            (head_item),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .temp_centideg_o   (temp_centideg_o),
    .press_centimbar_o (press_centimbar_o),
    .valid_res_o       (valid_res_o)
  );

endmodule

>>> rtl/bptc_checker.sv
// port-level checker for the barometer compensation block and its bind
`timescale 1ns / 1ps
`include "barometer_pressure_temp_compensation_defines.svh"

module bptc_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  out_valid_i,
  input logic                                  out_ready_i,
  input logic signed [bptc_pkg::OutTempW-1:0]  temp_centideg_i,
  input logic signed [bptc_pkg::OutPressW-1:0] press_centimbar_i,
  input logic                                  valid_res_i
);

  // a stalled result holds its fields
  `BPTC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(temp_centideg_i) && $stable(press_centimbar_i) && $stable(valid_res_i), "result changed while stalled")

  // valid drops only after a transfer
  `BPTC_ASSERT_IMP(a_out_drop, clk_i, rst_ni, $fell(out_valid_i), $past(out_ready_i), "result dropped without transfer")

  // out-of-range samples give zero fields
  `BPTC_ASSERT_IMP(a_range_zero, clk_i, rst_ni, out_valid_i && !valid_res_i, temp_centideg_i == '0 && press_centimbar_i == '0, "flagged result has nonzero fields")

  // corrected temperature stays inside the saturation limits
  `BPTC_ASSERT_IMP(a_temp_sat, clk_i, rst_ni, out_valid_i, temp_centideg_i >= -16'sd20000 && temp_centideg_i <= 16'sd20000, "temperature outside saturation range")

endmodule

bind barometer_pressure_temp_compensation bptc_checker u_bptc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .temp_centideg_i   (temp_centideg_o),
  .press_centimbar_i (press_centimbar_o),
  .valid_res_i       (valid_res_o)
);
